// ----- rtl/core/rgbad_pkg.sv -----
// Package with the shared types and constants of the RGBA pixel dimmer.
`default_nettype none
package rgbad_pkg;

  localparam int unsigned PixW = 8;
  localparam int unsigned CfgW = 9;
  localparam int unsigned CfgIdxW = 2;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    REG_DESAT_FACTOR = 2'd0,
    REG_COLOR_OFFSET = 2'd1,
    REG_ALPHA_GAIN   = 2'd2
  } cfg_reg_e;

  localparam logic [CfgW-1:0] DesatFull      = 9'd256;
  localparam logic [CfgW-1:0] DesatReset     = 9'd0;
  localparam logic [CfgW-1:0] OffsetReset    = 9'd0;
  localparam logic [CfgW-1:0] AlphaGainReset = 9'd256;

  // Reciprocal of three in Q0.11; exact floor for sums below 2048.
  localparam logic [9:0] RecipThree = 10'd683;
  localparam int unsigned RecipShift = 11;

  localparam logic [PixW-1:0] PixMax = 8'd255;

  // Color settings handed to each channel slice.
  typedef struct packed {
    logic        [CfgW-1:0] desat;
    logic signed [CfgW-1:0] offset;
  } color_cfg_t;

endpackage
`default_nettype wire

// ----- rtl/core/rgbad_if.sv -----
// Valid/ready stream interfaces for input and result pixels.
`default_nettype none
interface rgbad_in_if;
  import rgbad_pkg::*;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] in_red;
  logic [PixW-1:0] in_green;
  logic [PixW-1:0] in_blue;
  logic [PixW-1:0] in_alpha;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  output in_alpha, input ready);
  modport sink (input valid, input in_red, input in_green, input in_blue,
                input in_alpha, output ready);
endinterface

interface rgbad_out_if;
  import rgbad_pkg::*;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] out_red;
  logic [PixW-1:0] out_green;
  logic [PixW-1:0] out_blue;
  logic [PixW-1:0] out_alpha;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output out_alpha, input ready);
  modport sink (input valid, input out_red, input out_green, input out_blue,
                input out_alpha, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/rgbad_chan.sv -----
// One color channel: blend toward gray, add the offset and clamp.
`default_nettype none
module rgbad_chan
  import rgbad_pkg::*;
(
  input  wire logic [PixW-1:0] pix_i,
  input  wire logic [PixW-1:0] gray_i,
  input  color_cfg_t           cfg_i,
  output logic      [PixW-1:0] pix_o
);

  logic signed [PixW:0]        diff;
  logic signed [CfgW:0]        desat_s;
  logic signed [2*PixW+2:0]    prod;
  logic signed [2*PixW+2:0]    blend_sum;
  logic        [PixW-1:0]      blend;
  logic signed [PixW+1:0]      shifted;

  // Blend as p*256 + (gray - p)*d, which needs one multiplier.
  always_comb begin
    diff      = $signed({1'b0, gray_i}) - $signed({1'b0, pix_i});
    desat_s   = $signed({1'b0, cfg_i.desat});
    prod      = (2*PixW+3)'(diff * desat_s);
    blend_sum = $signed({3'b000, pix_i, 8'h00}) + prod;
    blend     = blend_sum[2*PixW-1:PixW];
  end

  // Add the signed offset and clamp to the pixel range.
  always_comb begin
    shifted = $signed({2'b00, blend}) + (PixW+2)'(cfg_i.offset);
    if (shifted < 0) begin
      pix_o = '0;
    end else if (shifted > $signed({2'b00, PixMax})) begin
      pix_o = PixMax;
    end else begin
      pix_o = shifted[PixW-1:0];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/rgba_pixel_dimmer.sv -----
// Top level of the RGBA pixel dimmer.
// Takes one 8-bit RGBA pixel per cycle while the output is not stalled and
// returns the dimmed pixel through three registers: an input register, a
// register holding gray and the scaled alpha, and the result register.
// Gray is the truncated mean of R, G and B; each color channel is blended
// toward it by desat_factor (Q0.8, values above 256 act as 256), gets
// color_offset added and is clamped to 0..255. Alpha is scaled by alpha_gain
// (Q1.8) and saturated at 255. Each stage moves on as soon as the next one
// is free, so a stalled result does not hold up stages that are still empty.
// Write the configuration only while no pixel is in flight.
`default_nettype none
module rgba_pixel_dimmer
  import rgbad_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgW-1:0]     cfg_wdata_i,
  rgbad_in_if.sink                 pix_i,
  rgbad_out_if.source              pix_o
);

  logic [CfgW-1:0] desat_q, offset_q, gain_q;
  color_cfg_t      color_cfg;

  logic            v0_q, v1_q, v2_q;
  logic            en0, en1, en2;
  logic [PixW-1:0] r0_q, g0_q, b0_q, a0_q;
  logic [PixW-1:0] r1_q, g1_q, b1_q, a1_q, gray1_q;
  logic [PixW-1:0] r2_q, g2_q, b2_q, a2_q;
  logic [PixW-1:0] r_d, g_d, b_d, a_d, gray_d;

  logic [PixW+1:0]          sum0;
  logic [PixW+RecipShift:0] gray_prod;
  logic [PixW+CfgW-1:0]     alpha_prod;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desat_q  <= DesatReset;
      offset_q <= OffsetReset;
      gain_q   <= AlphaGainReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DESAT_FACTOR: desat_q  <= cfg_wdata_i;
        REG_COLOR_OFFSET: offset_q <= cfg_wdata_i;
        REG_ALPHA_GAIN:   gain_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    color_cfg.desat  = (desat_q > DesatFull) ? DesatFull : desat_q;
    color_cfg.offset = $signed(offset_q);
  end

  // Each stage advances when it is empty or the next stage takes its item.
  assign en2 = !v2_q || pix_o.ready;
  assign en1 = !v1_q || en2;
  assign en0 = !v0_q || en1;
  assign pix_i.ready = en0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en0) v0_q <= pix_i.valid;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (en0 && pix_i.valid) begin
      r0_q <= pix_i.in_red;
      g0_q <= pix_i.in_green;
      b0_q <= pix_i.in_blue;
      a0_q <= pix_i.in_alpha;
    end
  end

  // Gray by multiplying with the reciprocal of three, and alpha scaling.
  always_comb begin
    sum0       = {2'b00, r0_q} + {2'b00, g0_q} + {2'b00, b0_q};
    gray_prod  = (PixW+RecipShift+1)'(sum0 * RecipThree);
    gray_d     = gray_prod[PixW+RecipShift-1:RecipShift];
    alpha_prod = a0_q * gain_q;
    a_d        = alpha_prod[PixW+CfgW-1] ? PixMax : alpha_prod[2*PixW-1:PixW];
  end

  always_ff @(posedge clk_i) begin
    if (en1 && v0_q) begin
      r1_q    <= r0_q;
      g1_q    <= g0_q;
      b1_q    <= b0_q;
      a1_q    <= a_d;
      gray1_q <= gray_d;
    end
  end

  // Color channels.
  rgbad_chan u_chan_r (.pix_i(r1_q), .gray_i(gray1_q), .cfg_i(color_cfg), .pix_o(r_d));
  rgbad_chan u_chan_g (.pix_i(g1_q), .gray_i(gray1_q), .cfg_i(color_cfg), .pix_o(g_d));
  rgbad_chan u_chan_b (.pix_i(b1_q), .gray_i(gray1_q), .cfg_i(color_cfg), .pix_o(b_d));

  // Result register.
  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      r2_q <= r_d;
      g2_q <= g_d;
      b2_q <= b_d;
      a2_q <= a1_q;
    end
  end

  assign pix_o.valid     = v2_q;
  assign pix_o.out_red   = r2_q;
  assign pix_o.out_green = g2_q;
  assign pix_o.out_blue  = b2_q;
  assign pix_o.out_alpha = a2_q;

  // The input side only stalls when every stage holds a pixel.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> (v0_q && v1_q && v2_q))
    else $error("input stalled while the pipeline has a free stage");

  // An accepted pixel lands in the input register.
  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_i.valid && pix_i.ready) |=> v0_q)
    else $error("accepted pixel lost at the input register");

  // A pixel leaving the middle stage reaches the result register.
  a_mid_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && en2) |=> pix_o.valid)
    else $error("pixel lost between the middle stage and the result");

endmodule
`default_nettype wire
